// ----- src/hexd_pkg.sv -----
// ----------------------------------------------------------------------------
// hexd_pkg
// Shared types and constants for the hex escape byte decoder.
// ----------------------------------------------------------------------------
package hexd_pkg;

  localparam int unsigned MaxOut = 4;

  localparam logic [7:0] BSL_CHAR = 8'h5c;
  localparam logic [7:0] X_CHAR   = 8'h78;

  // pending escape progress
  localparam logic [1:0] PEND_NONE = 2'd0;  // nothing held
  localparam logic [1:0] PEND_BSL  = 2'd1;  // backslash held
  localparam logic [1:0] PEND_X    = 2'd2;  // backslash and x held
  localparam logic [1:0] PEND_HEX  = 2'd3;  // backslash, x and one digit held

  typedef logic [MaxOut-1:0][7:0] byte_vec_t;

  // all results caused by one input word
  typedef struct packed {
    byte_vec_t  bytes;     // result bytes, entry 0 goes out first
    logic [1:0] last_idx;  // index of the final result
    logic       end_flag;  // input word carried the end of text
    logic       none;      // input word produced no byte
  } group_t;

endpackage

// ----- src/hexd_step.sv -----
// ----------------------------------------------------------------------------
// hexd_step
// One decode step: pending escape state and one raw byte in, result group
// and next pending state out.
// ----------------------------------------------------------------------------
module hexd_step (
  input  logic [1:0]      pend_count,
  input  logic [7:0]      pend_hex,
  input  logic [7:0]      in_byte,
  input  logic            in_end,
  output logic [1:0]      pend_count_next,
  output logic [7:0]      pend_hex_next,
  output hexd_pkg::group_t grp
);

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  hexd_pkg::byte_vec_t bytes;
  logic [2:0]          cnt;
  logic                b_hex;
  logic                b_bsl;
  logic                b_x;
  logic [2:0]          cnt_m1;

  assign b_hex = is_hex(in_byte);
  assign b_bsl = (in_byte == hexd_pkg::BSL_CHAR);
  assign b_x   = (in_byte == hexd_pkg::X_CHAR);

  always_comb begin
    bytes           = '0;
    cnt             = 3'd0;
    pend_count_next = hexd_pkg::PEND_NONE;
    pend_hex_next   = 8'd0;
    case (pend_count)
      hexd_pkg::PEND_NONE: begin
        if (b_bsl && !in_end) begin
          pend_count_next = hexd_pkg::PEND_BSL;
        end else begin
          bytes[0] = in_byte;
          cnt      = 3'd1;
        end
      end
      hexd_pkg::PEND_BSL: begin
        if (b_x) begin
          if (in_end) begin
            bytes[0] = hexd_pkg::BSL_CHAR;
            bytes[1] = hexd_pkg::X_CHAR;
            cnt      = 3'd2;
          end else begin
            pend_count_next = hexd_pkg::PEND_X;
          end
        end else if (b_bsl) begin
          bytes[0] = hexd_pkg::BSL_CHAR;
          cnt      = 3'd1;
        end else begin
          bytes[0] = hexd_pkg::BSL_CHAR;
          bytes[1] = in_byte;
          cnt      = 3'd2;
        end
      end
      hexd_pkg::PEND_X: begin
        if (!in_end && b_hex) begin
          pend_count_next = hexd_pkg::PEND_HEX;
          pend_hex_next   = in_byte;
        end else begin
          bytes[0] = hexd_pkg::BSL_CHAR;
          bytes[1] = hexd_pkg::X_CHAR;
          cnt      = 3'd2;
          // failing byte looked at again from the empty state
          if (b_bsl && !in_end) begin
            pend_count_next = hexd_pkg::PEND_BSL;
          end else begin
            bytes[2] = in_byte;
            cnt      = 3'd3;
          end
        end
      end
      default: begin
        if (b_hex) begin
          bytes[0] = {hex_val(pend_hex), hex_val(in_byte)};
          cnt      = 3'd1;
        end else begin
          bytes[0] = hexd_pkg::BSL_CHAR;
          bytes[1] = hexd_pkg::X_CHAR;
          bytes[2] = pend_hex;
          cnt      = 3'd3;
          if (b_bsl && !in_end) begin
            pend_count_next = hexd_pkg::PEND_BSL;
          end else begin
            bytes[3] = in_byte;
            cnt      = 3'd4;
          end
        end
      end
    endcase
  end

  assign cnt_m1       = cnt - 3'd1;
  assign grp.bytes    = bytes;
  assign grp.none     = (cnt == 3'd0);
  assign grp.last_idx = (cnt == 3'd0) ? 2'd0 : cnt_m1[1:0];
  assign grp.end_flag = in_end;

endmodule

// ----- src/hex_escape_byte_decoder.sv -----
// ----------------------------------------------------------------------------
// hex_escape_byte_decoder
// results: a taken word's result group is written to the queue register; its
//   results leave in order through the single output port and a two-group queue
// throughput: one input word per cycle while the queue is not full (in_stall)
// reset: synchronous rst empties the queue and clears any pending escape
// Decodes backslash-x hex pairs and doubled backslashes in a byte stream.
// ----------------------------------------------------------------------------
module hex_escape_byte_decoder (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       text_end,
  output logic       none_out
);

  // pending escape state
  logic [1:0] pend_count;
  logic [7:0] pend_hex;
  logic [1:0] pend_count_next;
  logic [7:0] pend_hex_next;

  hexd_pkg::group_t grp_new;

  // two-entry queue of result groups, one group per input word
  hexd_pkg::group_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_count;
  logic [1:0] idx;      // result within the head group

  logic in_take;
  logic out_take;
  logic pop;
  hexd_pkg::group_t head;

  hexd_step u_step (
    .pend_count      (pend_count),
    .pend_hex        (pend_hex),
    .in_byte         (in_byte),
    .in_end          (in_end),
    .pend_count_next (pend_count_next),
    .pend_hex_next   (pend_hex_next),
    .grp             (grp_new)
  );

  // stall only on a full queue, so it never waits on out_stall in the same cycle
  assign in_stall = (q_count == 2'd2);
  assign in_take  = in_valid && !in_stall;

  assign head      = q[rd_ptr];
  assign out_valid = (q_count != 2'd0);
  assign out_byte  = head.bytes[idx];
  assign run_last  = (idx == head.last_idx);
  assign text_end  = run_last && head.end_flag && !head.none;
  assign none_out  = head.none;

  assign out_take = out_valid && !out_stall;
  // the group leaves once its final result has gone
  assign pop      = out_take && run_last;

  // escape state moves with every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= hexd_pkg::PEND_NONE;
      pend_hex   <= 8'd0;
    end else if (in_take) begin
      pend_count <= pend_count_next;
      pend_hex   <= pend_hex_next;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      q[wr_ptr] <= grp_new;
    end
  end

  // queue control and result index
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
      idx     <= 2'd0;
    end else begin
      if (in_take) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
        idx    <= 2'd0;
      end else if (out_take) begin
        idx <= idx + 2'd1;
      end
      if (in_take && !pop) begin
        q_count <= q_count + 2'd1;
      end else if (pop && !in_take) begin
        q_count <= q_count - 2'd1;
      end
    end
  end

endmodule
